// ===== hw/rtl/e2b_pkg.sv =====
// Shared constants and helper functions for the Euler-angle to basis-vector block.
package e2b_pkg;

    localparam int ANG_W       = 18;
    localparam int ANGLE_FULL  = 92160;
    localparam int ANGLE_QTR   = 23040;
    localparam int DEF_OUT_W   = 16;
    localparam int DEF_STEPS   = 16;
    localparam int MAX_STEPS   = 32;
    localparam int CW          = 34;  // Q2.30 plus guard bits for CORDIC
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [47:0] ANG_K = 48'd4797524517;

    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        cval_t  x;
        cval_t  y;
        cval_t  z;
        logic [1:0] q;
    } cordic_t;

    function automatic cval_t atan_q30(input int i);
        cval_t v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            default: v = (i < 31) ? (cval_t'(1) <<< (30 - i)) : cval_t'(0);
        endcase
        return v;
    endfunction

    // Q2.30 product rounded back to Q2.30
    function automatic cval_t qmul(input cval_t a, input cval_t b);
        logic signed [2*CW-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return cval_t'(p >>> 30);
    endfunction

endpackage

// ===== hw/rtl/e2b_reduce.sv =====
// Angle wrap, quadrant split and residue scaling to Q2.30 radians.
module e2b_reduce
    import e2b_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] ang,
    output cordic_t                 cell_out
);
    logic signed [ANG_W:0] w1, w2;
    logic [16:0]  a_reg;
    logic [1:0]   q;
    logic [14:0]  r;
    logic [16:0]  t1, t2;
    logic [62:0]  prod;

    // input range is -131072..131071, so at most two adds/subtracts of 360 deg
    always_comb begin
        w1 = ang;
        if (w1 < 0) w1 = w1 + (ANG_W+1)'(ANGLE_FULL);
        if (w1 < 0) w1 = w1 + (ANG_W+1)'(ANGLE_FULL);
        if (w1 >= (ANG_W+1)'(ANGLE_FULL)) w1 = w1 - (ANG_W+1)'(ANGLE_FULL);
        w2 = w1;
    end

    always_ff @(posedge aclk) begin
        if (en) a_reg <= w2[16:0];
    end

    always_comb begin
        t1 = a_reg;
        q  = 2'd0;
        if (t1 >= 17'(2*ANGLE_QTR)) begin
            t1 = t1 - 17'(2*ANGLE_QTR);
            q[1] = 1'b1;
        end
        t2 = t1;
        if (t2 >= 17'(ANGLE_QTR)) begin
            t2 = t2 - 17'(ANGLE_QTR);
            q[0] = 1'b1;
        end
        r    = t2[14:0];
        prod = 63'(r) * 63'(ANG_K) + 63'd32768;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out.x <= CORDIC_GAIN;
            cell_out.y <= '0;
            cell_out.z <= cval_t'(prod >> 16);
            cell_out.q <= q;
        end
    end
endmodule

// ===== hw/rtl/e2b_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation, registered.
module e2b_cordic_cell
    import e2b_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic    aclk,
    input  logic    en,
    input  cordic_t cell_in,
    output cordic_t cell_out
);
    cval_t dx, dy;
    localparam cval_t ATAN = atan_q30(IDX);

    assign dx = cell_in.y >>> IDX;
    assign dy = cell_in.x >>> IDX;

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out.q <= cell_in.q;
            if (!cell_in.z[CW-1]) begin
                cell_out.x <= cell_in.x - dx;
                cell_out.y <= cell_in.y + dy;
                cell_out.z <= cell_in.z - ATAN;
            end else begin
                cell_out.x <= cell_in.x + dx;
                cell_out.y <= cell_in.y - dy;
                cell_out.z <= cell_in.z + ATAN;
            end
        end
    end
endmodule

// ===== hw/rtl/e2b_sincos.sv =====
// Angle reduction followed by a chain of CORDIC cells; yields sine and cosine.
module e2b_sincos
    import e2b_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_STEPS
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] ang,
    output cval_t                   sin_o,
    output cval_t                   cos_o
);
    localparam int N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    cordic_t chain [N+1];

    e2b_reduce u_red (.aclk(aclk), .en(en), .ang(ang), .cell_out(chain[0]));

    for (genvar i = 0; i < N; i++) begin : g_cell
        e2b_cordic_cell #(.IDX(i)) u_cell (
            .aclk(aclk), .en(en), .cell_in(chain[i]), .cell_out(chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (chain[N].q)
                2'd0: begin sin_o <= chain[N].y;  cos_o <= chain[N].x;  end
                2'd1: begin sin_o <= chain[N].x;  cos_o <= -chain[N].y; end
                2'd2: begin sin_o <= -chain[N].y; cos_o <= -chain[N].x; end
                default: begin sin_o <= -chain[N].x; cos_o <= chain[N].y; end
            endcase
        end
    end
endmodule

// ===== hw/rtl/euler_to_basis_vectors.sv =====
// Top level: three sine/cosine chains, product stages and output saturation.
// One transaction per cycle enters when the pipeline can advance. Stages are
// two for angle reduction, one per CORDIC cell (CORDIC_STEPS, max 32), one
// for quadrant mapping, two product stages and one output stage.
// The whole pipeline advances only when the output register is free or taken.
module euler_to_basis_vectors
    import e2b_pkg::*;
#(
    parameter int OUT_WIDTH    = DEF_OUT_W,
    parameter int CORDIC_STEPS = DEF_STEPS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [55:0]            s_tdata,  // pitch_deg, yaw_deg, roll_deg
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, up_x, up_y, up_z
    output logic [((9*OUT_WIDTH+7)/8)*8-1:0] m_tdata
);
    localparam int N   = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int LAT = N + 6;
    localparam int FR  = OUT_WIDTH - 1;
    localparam int OW  = ((9*OUT_WIDTH+7)/8)*8;

    logic en;
    logic [LAT-2:0] vld_reg;
    cval_t sp, cp, sy, cy, sr, cr;
    cval_t srsp_reg, crsp_reg, cp1_reg, sp1_reg, sy1_reg, cy1_reg, sr1_reg, cr1_reg;
    cval_t comp_reg [9];
    logic [OUT_WIDTH-1:0] res [9];
    logic [OW-1:0] res_flat;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    e2b_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_p (.aclk(aclk), .en(en),
        .ang(s_tdata[17:0]),  .sin_o(sp), .cos_o(cp));
    e2b_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_y (.aclk(aclk), .en(en),
        .ang(s_tdata[35:18]), .sin_o(sy), .cos_o(cy));
    e2b_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_r (.aclk(aclk), .en(en),
        .ang(s_tdata[53:36]), .sin_o(sr), .cos_o(cr));

    always_ff @(posedge aclk) begin
        if (en) begin
            srsp_reg <= qmul(sr, sp);
            crsp_reg <= qmul(cr, sp);
            cp1_reg <= cp; sp1_reg <= sp; sy1_reg <= sy;
            cy1_reg <= cy; sr1_reg <= sr; cr1_reg <= cr;
            comp_reg[0] <= qmul(cp1_reg, cy1_reg);
            comp_reg[1] <= qmul(cp1_reg, sy1_reg);
            comp_reg[2] <= -sp1_reg;
            comp_reg[3] <= qmul(cr1_reg, sy1_reg) - qmul(srsp_reg, cy1_reg);
            comp_reg[4] <= -qmul(srsp_reg, sy1_reg) - qmul(cr1_reg, cy1_reg);
            comp_reg[5] <= -qmul(sr1_reg, cp1_reg);
            comp_reg[6] <= qmul(crsp_reg, cy1_reg) + qmul(sr1_reg, sy1_reg);
            comp_reg[7] <= qmul(crsp_reg, sy1_reg) - qmul(sr1_reg, cy1_reg);
            comp_reg[8] <= qmul(cr1_reg, cp1_reg);
        end
    end

    // Q2.30 to Q1.FR with round half up and saturation
    for (genvar k = 0; k < 9; k++) begin : g_sat
        logic signed [CW+2:0] v, sc;
        localparam logic signed [CW+2:0] HI = (CW+3)'((64'sd1 <<< FR) - 1);
        localparam logic signed [CW+2:0] LO = -(CW+3)'(64'sd1 <<< FR);
        always_comb begin
            v = (CW+3)'(comp_reg[k]);
            if (FR < 30)
                sc = (v + ((CW+3)'(1) <<< (29 - FR))) >>> (30 - FR);
            else
                sc = v <<< (FR - 30);
            if (sc > HI) sc = HI;
            if (sc < LO) sc = LO;
            res[k] = sc[OUT_WIDTH-1:0];
        end
    end

    // pad bits above the nine fields stay zero
    always_comb begin
        res_flat = '0;
        for (int k = 0; k < 9; k++)
            res_flat[k*OUT_WIDTH +: OUT_WIDTH] = res[k];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= res_flat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            m_tvalid <= 1'b0;
        end else if (en) begin
            vld_reg  <= {vld_reg[LAT-3:0], s_tvalid};
            m_tvalid <= vld_reg[LAT-2];
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[LAT-2] |=> m_tvalid)
        else $error("pipeline item lost");
endmodule
